/* hdl/fetr_pkg.sv */
// ----------------------------------------------------------------------------
// fetr_pkg
// Shared types and constants for the filtered event trace ring.
// ----------------------------------------------------------------------------
package fetr_pkg;

    localparam int RING_DEPTH_DEF = 32;
    localparam int MAX_ARGS       = 4;
    localparam int CNT_W          = 6;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_TAIL = 1'b1;

    localparam logic REC_SUMMARY = 1'b0;
    localparam logic REC_ENTRY   = 1'b1;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_ALL = 2'd1;

    localparam logic REG_TRACE_MODE = 1'b0;
    localparam logic REG_FILTER_MOD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB_AVAIL,
        ST_SUB_DROP,
        ST_SUMMARY,
        ST_READ,
        ST_EMIT
    } fetr_state_t;

    typedef struct packed {
        logic [63:0] ts;
        logic [31:0] src_module;
        logic [31:0] ev_kind;
        logic [31:0] thread;
        logic [2:0]  argc;
        logic [63:0] arg0;
        logic [63:0] arg1;
        logic [63:0] arg2;
        logic [63:0] arg3;
        logic [63:0] ret;
    } fetr_entry_t;

    typedef struct packed {
        logic              record_type;
        logic [63:0]       word_a;
        logic [31:0]       word_b;
        logic [CNT_W-1:0]  count_field;
        logic [31:0]       ev_kind;
        logic [31:0]       thread;
        logic [63:0]       arg0;
        logic [63:0]       arg1;
        logic [63:0]       arg2;
        logic [63:0]       arg3;
        logic [63:0]       ret;
        logic              last;
    } fetr_rec_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
    } fetr_sub_op_t;

    typedef struct packed {
        logic [63:0] diff;
        logic        borrow;
    } fetr_sub_res_t;

endpackage

/* hdl/fetr_req_if.sv */
// ----------------------------------------------------------------------------
// fetr_req_if
// Request channel: push words and tail read requests.
// ----------------------------------------------------------------------------
interface fetr_req_if;
    import fetr_pkg::*;

    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] src_module;
    logic [31:0] event_kind;
    logic [7:0]  arg_count;
    logic [63:0] arg_zero;
    logic [63:0] arg_one;
    logic [63:0] arg_two;
    logic [63:0] arg_three;
    logic [63:0] ret_value;
    logic [63:0] time_stamp;
    logic [31:0] thread_tag;
    logic [63:0] last_seen_seq;

    modport source (
        output valid, kind, src_module, event_kind, arg_count, arg_zero, arg_one,
               arg_two, arg_three, ret_value, time_stamp, thread_tag, last_seen_seq,
        input  ready
    );

    modport sink (
        input  valid, kind, src_module, event_kind, arg_count, arg_zero, arg_one,
               arg_two, arg_three, ret_value, time_stamp, thread_tag, last_seen_seq,
        output ready
    );
endinterface

/* hdl/fetr_rsp_if.sv */
// ----------------------------------------------------------------------------
// fetr_rsp_if
// Response channel: summary and trace entry records.
// ----------------------------------------------------------------------------
interface fetr_rsp_if;
    import fetr_pkg::*;

    logic             valid;
    logic             ready;
    logic             record_type;
    logic [63:0]      word_a;
    logic [31:0]      word_b;
    logic [CNT_W-1:0] count_field;
    logic [31:0]      out_event_kind;
    logic [31:0]      out_thread;
    logic [63:0]      out_arg_zero;
    logic [63:0]      out_arg_one;
    logic [63:0]      out_arg_two;
    logic [63:0]      out_arg_three;
    logic [63:0]      out_ret;
    logic             last;

    modport source (
        output valid, record_type, word_a, word_b, count_field, out_event_kind,
               out_thread, out_arg_zero, out_arg_one, out_arg_two, out_arg_three,
               out_ret, last,
        input  ready
    );

    modport sink (
        input  valid, record_type, word_a, word_b, count_field, out_event_kind,
               out_thread, out_arg_zero, out_arg_one, out_arg_two, out_arg_three,
               out_ret, last,
        output ready
    );
endinterface

/* hdl/fetr_ram.sv */
// ----------------------------------------------------------------------------
// fetr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fetr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* hdl/fetr_sub.sv */
// ----------------------------------------------------------------------------
// fetr_sub
// Shared 64-bit subtractor with borrow, used for both tail read steps.
// ----------------------------------------------------------------------------
module fetr_sub (
    input  fetr_pkg::fetr_sub_op_t  op,
    output fetr_pkg::fetr_sub_res_t res
);
    import fetr_pkg::*;

    logic [64:0] full;

    assign full       = {1'b0, op.a} - {1'b0, op.b};
    assign res.diff   = full[63:0];
    assign res.borrow = full[64];
endmodule

/* hdl/fetr_seq.sv */
// ----------------------------------------------------------------------------
// fetr_seq
// Tail read sequencer: count/drop arithmetic, ring walk and output register.
// ----------------------------------------------------------------------------
module fetr_seq #(
    parameter int RING_DEPTH = fetr_pkg::RING_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tail_start,
    input  logic [63:0]                   last_seen,
    input  logic [63:0]                   seq_count,
    input  logic [$clog2(RING_DEPTH)-1:0] head,
    output logic                          busy,
    output fetr_pkg::fetr_sub_op_t        sub_op,
    input  fetr_pkg::fetr_sub_res_t       sub_res,
    output logic                          rd_en,
    output logic [$clog2(RING_DEPTH)-1:0] rd_addr,
    input  fetr_pkg::fetr_entry_t         rd_data,
    fetr_rsp_if.source                    rsp
);
    import fetr_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int PTR_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RING_DEPTH - 1);
    localparam logic [PTR_W-1:0] DEPTH_P   = PTR_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);
    localparam logic [63:0]      DEPTH_64  = 64'(RING_DEPTH);

    fetr_state_t      state_reg, state_next;
    logic [63:0]      last_reg;
    logic [63:0]      diff_reg;
    logic             gt_reg;
    logic [CNT_W-1:0] n_reg;
    logic [31:0]      drop_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic [CNT_W-1:0] k_reg;
    logic             valid_reg;
    fetr_rec_t        rec_reg;

    logic             out_free;
    logic             load_sum;
    logic             load_ent;
    logic             sub_gt;
    logic             last_ent;
    logic [PTR_W-1:0] start_sum;
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] ptr_inc;
    fetr_rec_t        sum_rec;
    fetr_rec_t        ent_rec;

    assign out_free = !valid_reg || rsp.ready;
    assign sub_gt   = !sub_res.borrow && (sub_res.diff != 64'd0);
    assign last_ent = (k_reg + CNT_W'(1)) == n_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tail_start)
                begin
                    state_next = ST_SUB_AVAIL;
                end
            end
            ST_SUB_AVAIL:
            begin
                state_next = ST_SUB_DROP;
            end
            ST_SUB_DROP:
            begin
                state_next = ST_SUMMARY;
            end
            ST_SUMMARY:
            begin
                if (out_free)
                begin
                    state_next = (n_reg == '0) ? ST_IDLE : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_ent ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy     = 1'b1;
        rd_en    = 1'b0;
        load_sum = 1'b0;
        load_ent = 1'b0;
        sub_op.a = diff_reg;
        sub_op.b = DEPTH_64;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_SUB_AVAIL:
            begin
                sub_op.a = seq_count;
                sub_op.b = last_reg;
            end
            ST_SUB_DROP:
            begin
                sub_op.a = diff_reg;
                sub_op.b = DEPTH_64;
            end
            ST_SUMMARY:
            begin
                load_sum = out_free;
            end
            ST_READ:
            begin
                rd_en = 1'b1;
            end
            ST_EMIT:
            begin
                load_ent = out_free;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign rd_addr = ptr_reg;

    // oldest returned entry: head - n, wrapped
    assign start_sum = {1'b0, head} + DEPTH_P - PTR_W'(n_reg);
    assign start_idx = (start_sum >= DEPTH_P) ? IDX_W'(start_sum - DEPTH_P)
                                              : IDX_W'(start_sum);
    assign ptr_inc   = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + IDX_W'(1);

    always_comb
    begin
        sum_rec             = '0;
        sum_rec.record_type = REC_SUMMARY;
        sum_rec.word_a      = seq_count;
        sum_rec.word_b      = drop_reg;
        sum_rec.count_field = n_reg;
        sum_rec.last        = (n_reg == '0);

        ent_rec.record_type = REC_ENTRY;
        ent_rec.word_a      = rd_data.ts;
        ent_rec.word_b      = rd_data.src_module;
        ent_rec.count_field = CNT_W'(rd_data.argc);
        ent_rec.ev_kind     = rd_data.ev_kind;
        ent_rec.thread      = rd_data.thread;
        ent_rec.arg0        = rd_data.arg0;
        ent_rec.arg1        = rd_data.arg1;
        ent_rec.arg2        = rd_data.arg2;
        ent_rec.arg3        = rd_data.arg3;
        ent_rec.ret         = rd_data.ret;
        ent_rec.last        = last_ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_sum || load_ent)
            begin
                valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_start)
        begin
            last_reg <= last_seen;
        end
        if (state_reg == ST_SUB_AVAIL)
        begin
            diff_reg <= sub_res.diff;
            gt_reg   <= sub_gt;
        end
        if (state_reg == ST_SUB_DROP)
        begin
            if (gt_reg && sub_gt)
            begin
                n_reg    <= DEPTH_CNT;
                drop_reg <= sub_res.diff[31:0];
            end
            else if (gt_reg)
            begin
                n_reg    <= diff_reg[CNT_W-1:0];
                drop_reg <= '0;
            end
            else
            begin
                n_reg    <= '0;
                drop_reg <= '0;
            end
        end
        if (load_sum)
        begin
            ptr_reg <= start_idx;
            k_reg   <= '0;
            rec_reg <= sum_rec;
        end
        if (load_ent)
        begin
            ptr_reg <= ptr_inc;
            k_reg   <= k_reg + CNT_W'(1);
            rec_reg <= ent_rec;
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.record_type    = rec_reg.record_type;
    assign rsp.word_a         = rec_reg.word_a;
    assign rsp.word_b         = rec_reg.word_b;
    assign rsp.count_field    = rec_reg.count_field;
    assign rsp.out_event_kind = rec_reg.ev_kind;
    assign rsp.out_thread     = rec_reg.thread;
    assign rsp.out_arg_zero   = rec_reg.arg0;
    assign rsp.out_arg_one    = rec_reg.arg1;
    assign rsp.out_arg_two    = rec_reg.arg2;
    assign rsp.out_arg_three  = rec_reg.arg3;
    assign rsp.out_ret        = rec_reg.ret;
    assign rsp.last           = rec_reg.last;
endmodule

/* hdl/filtered_event_trace_ring_top.sv */
// ----------------------------------------------------------------------------
// filtered_event_trace_ring_top
// Overwriting trace ring with module filter and sequence-based tail read.
//
//   channel  dir  handshake       word
//   req      in   valid/ready     push event or tail read request
//   rsp      out  valid/ready     summary record, then entry records
//   apb      in   psel/penable    trace_mode (0x0), filter_module (0x4)
//
// A push is written to the ring at the edge where it is accepted.
// A tail read holds req.ready low while it runs: two steps of the shared
// subtractor, the summary, then one ring read and one emit per entry
// through the single RAM read port.
// rsp stalls extend the read; the ring needs no clearing after reset.
// ----------------------------------------------------------------------------
module filtered_event_trace_ring_top #(
    parameter int RING_DEPTH = fetr_pkg::RING_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fetr_req_if.sink                      req,
    fetr_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fetr_pkg::APB_AW-1:0]   paddr,
    input  logic [fetr_pkg::APB_DW-1:0]   pwdata,
    output logic [fetr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import fetr_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    logic [1:0]       mode_reg;
    logic [31:0]      filter_reg;
    logic [IDX_W-1:0] head_reg;
    logic [63:0]      seq_reg;

    logic             busy;
    logic             accept;
    logic             pass;
    logic             push_we;
    logic             tail_start;
    logic             cfg_we;
    logic [2:0]       argc;
    fetr_entry_t      wr_entry;
    fetr_entry_t      rd_entry;
    fetr_sub_op_t     sub_op;
    fetr_sub_res_t    sub_res;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_FILTER_MOD) ? filter_reg : {30'd0, mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_OFF;
            filter_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_TRACE_MODE)
            begin
                mode_reg <= pwdata[1:0];
            end
            else
            begin
                filter_reg <= pwdata;
            end
        end
    end

    assign req.ready  = !busy;
    assign accept     = req.valid && req.ready;
    assign pass       = (mode_reg == MODE_ALL) ||
                        ((mode_reg != MODE_OFF) && (req.src_module == filter_reg));
    assign push_we    = accept && (req.kind == KIND_PUSH) && pass;
    assign tail_start = accept && (req.kind == KIND_TAIL);
    assign argc       = (req.arg_count > 8'(MAX_ARGS)) ? 3'(MAX_ARGS)
                                                      : req.arg_count[2:0];

    always_comb
    begin
        wr_entry.ts         = req.time_stamp;
        wr_entry.src_module = req.src_module;
        wr_entry.ev_kind    = req.event_kind;
        wr_entry.thread     = req.thread_tag;
        wr_entry.argc       = argc;
        wr_entry.arg0       = (argc > 3'd0) ? req.arg_zero  : '0;
        wr_entry.arg1       = (argc > 3'd1) ? req.arg_one   : '0;
        wr_entry.arg2       = (argc > 3'd2) ? req.arg_two   : '0;
        wr_entry.arg3       = (argc > 3'd3) ? req.arg_three : '0;
        wr_entry.ret        = req.ret_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            seq_reg  <= '0;
        end
        else if (push_we)
        begin
            head_reg <= (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
            seq_reg  <= seq_reg + 64'd1;
        end
    end

    fetr_ram #(
        .WIDTH ($bits(fetr_entry_t)),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (push_we),
        .waddr (head_reg),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    fetr_sub u_sub (
        .op  (sub_op),
        .res (sub_res)
    );

    fetr_seq #(
        .RING_DEPTH (RING_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_start (tail_start),
        .last_seen  (req.last_seen_seq),
        .seq_count  (seq_reg),
        .head       (head_reg),
        .busy       (busy),
        .sub_op     (sub_op),
        .sub_res    (sub_res),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_entry),
        .rsp        (rsp)
    );
endmodule
